// ===== hdl/mwt_pkg.sv =====
`timescale 1ns / 1ps

package mwt_pkg;

  localparam int OP_WIDTH     = 1;
  localparam int STATUS_WIDTH = 3;
  localparam int PORT_ID_W    = 8;

  localparam logic [OP_WIDTH-1:0] OP_ACQUIRE = 1'b0;
  localparam logic [OP_WIDTH-1:0] OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_GRANTED     = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_WAIT_FULL   = 3'd2,
    ST_FREED       = 3'd3,
    ST_HANDED_OVER = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;   // capture the request on a start transfer
    logic find;    // register slot search and read the wait table
    logic apply;   // update lock state and produce the result
  } dp_cmd_t;

endpackage

// ===== hdl/mwt_ctrl.sv =====
`timescale 1ns / 1ps

module mwt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output mwt_pkg::dp_cmd_t cmd,
  output logic             out_valid
);
  import mwt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_APPLY
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_FIND;
      S_FIND:  state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_APPLY);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cmd.latch = start && (state_r == S_IDLE);
  assign cmd.find  = (state_r == S_FIND);
  assign cmd.apply = (state_r == S_APPLY);
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/mwt_dp.sv =====
`timescale 1ns / 1ps

module mwt_dp #(
  parameter int WAIT_SLOTS = 8,
  parameter int ID_WIDTH   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mwt_pkg::dp_cmd_t                    cmd,
  input  logic [mwt_pkg::OP_WIDTH-1:0]        in_operation,
  input  logic [mwt_pkg::PORT_ID_W-1:0]       in_requester_id,
  output logic [mwt_pkg::STATUS_WIDTH-1:0]    out_status,
  output logic [mwt_pkg::PORT_ID_W-1:0]       out_woken_id,
  output logic                                out_lock_held
);
  import mwt_pkg::*;

  localparam int IDX_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;

  logic [OP_WIDTH-1:0]   op_r;
  logic [ID_WIDTH-1:0]   rid_r;
  logic                  held_r;
  logic [WAIT_SLOTS-1:0] used_r;

  // wait table; a read entry is used only while its used bit is set
  logic [ID_WIDTH-1:0]   id_mem [WAIT_SLOTS];
  logic [ID_WIDTH-1:0]   rd_id_r;

  logic [IDX_W-1:0]      free_idx, used_idx;
  logic                  free_any, used_any;
  logic [IDX_W-1:0]      free_idx_r, used_idx_r;
  logic                  free_any_r, used_any_r;

  status_t               status_r;
  logic [ID_WIDTH-1:0]   woken_r;

  // lowest free and lowest occupied slot
  always_comb begin
    free_idx = '0;
    used_idx = '0;
    free_any = 1'b0;
    used_any = 1'b0;
    for (int i = WAIT_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
      if (used_r[i]) begin
        used_idx = IDX_W'(i);
        used_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_operation;
      rid_r <= ID_WIDTH'(in_requester_id);
    end
    if (cmd.find) begin
      free_idx_r <= free_idx;
      used_idx_r <= used_idx;
      free_any_r <= free_any;
      used_any_r <= used_any;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      rd_id_r <= id_mem[used_idx];
    end
    if (cmd.apply && (op_r == OP_ACQUIRE) && held_r && free_any_r) begin
      id_mem[free_idx_r] <= rid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      used_r <= '0;
    end else if (cmd.apply) begin
      if (op_r == OP_ACQUIRE) begin
        if (!held_r) begin
          held_r <= 1'b1;
        end else if (free_any_r) begin
          used_r[free_idx_r] <= 1'b1;
        end
      end else begin
        if (used_any_r) begin
          used_r[used_idx_r] <= 1'b0;
          held_r <= 1'b1;
        end else begin
          held_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      woken_r <= '0;
      if (op_r == OP_ACQUIRE) begin
        if (!held_r)         status_r <= ST_GRANTED;
        else if (free_any_r) status_r <= ST_QUEUED;
        else                 status_r <= ST_WAIT_FULL;
      end else begin
        if (used_any_r) begin
          status_r <= ST_HANDED_OVER;
          woken_r  <= rd_id_r;
        end else begin
          status_r <= ST_FREED;
        end
      end
    end
  end

  assign out_status    = status_r;
  assign out_woken_id  = PORT_ID_W'(woken_r);
  assign out_lock_held = held_r;

endmodule

// ===== hdl/mutex_with_wait_table_top.sv =====
`timescale 1ns / 1ps

// channel  | handshake                | payload
// request  | start, busy              | in_operation, in_requester_id
// result   | out_valid (1-cycle pulse)| out_status, out_woken_id, out_lock_held
//
// A request transfers when start is high and busy is low. It is handled in
// three steps: capture, slot search plus wait-table read, then state update.
// The result strobes for one cycle after the update. A new request may
// transfer during that strobe. Synchronous active-low reset unlocks and
// empties the table. The receiver cannot stall; results are never held.

module mutex_with_wait_table_top #(
  parameter int WAIT_SLOTS = 8,
  parameter int ID_WIDTH   = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [mwt_pkg::OP_WIDTH-1:0]     in_operation,
  input  logic [mwt_pkg::PORT_ID_W-1:0]    in_requester_id,
  output logic                             out_valid,
  output logic [mwt_pkg::STATUS_WIDTH-1:0] out_status,
  output logic [mwt_pkg::PORT_ID_W-1:0]    out_woken_id,
  output logic                             out_lock_held
);
  import mwt_pkg::*;

  dp_cmd_t cmd;

  mwt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  mwt_dp #(
    .WAIT_SLOTS (WAIT_SLOTS),
    .ID_WIDTH   (ID_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_requester_id (in_requester_id),
    .out_status      (out_status),
    .out_woken_id    (out_woken_id),
    .out_lock_held   (out_lock_held)
  );

endmodule
